/* src/gcf_pkg.sv */
package gcf_pkg;

    // Longest allowed line body; a frame may carry LINE_LIMIT+2 bytes.
    localparam int unsigned LINE_LIMIT = 128;
    localparam logic [8:0] FRAME_MAX = 9'(LINE_LIMIT + 2);

    // Characters used in the prefix and the trailer.
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    // Decimal conversion sizes.
    localparam int unsigned DEC_DIGITS = 10;
    localparam logic [3:0] DEC_DIGITS_CODE = 4'd10;
    localparam logic [4:0] DABBLE_LAST = 5'd31;
    localparam logic [4:0] DABBLE_FROM_SUM = 5'd24;

    typedef logic [4:0] step_t;

    // Datapath action selected by one control word.
    typedef enum logic [3:0] {
        ACT_FETCH,
        ACT_OPEN,
        ACT_JMP_PLAIN,
        ACT_JMP_NOT_LAST,
        ACT_LIT,
        ACT_DATA,
        ACT_LOAD_LINE,
        ACT_LOAD_SUM,
        ACT_DABBLE,
        ACT_SKIP,
        ACT_DIGIT,
        ACT_LF
    } act_t;

    typedef struct packed {
        act_t       act;
        logic [7:0] lit;
        logic       summed;
        step_t      target;
    } ctrl_t;

    // Program step addresses that are jump targets.
    localparam step_t STEP_FETCH = 5'd0;
    localparam step_t STEP_DATA  = 5'd9;
    localparam step_t STEP_CR    = 5'd18;

    // Control store of the framing sequencer.
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t cw;
        cw = '{act: ACT_FETCH, lit: 8'h00, summed: 1'b0, target: STEP_FETCH};
        unique case (step)
            5'd0:  cw = '{ACT_FETCH,        8'h00,      1'b0, STEP_FETCH};
            5'd1:  cw = '{ACT_OPEN,         8'h00,      1'b0, STEP_DATA};
            5'd2:  cw = '{ACT_JMP_PLAIN,    8'h00,      1'b0, STEP_DATA};
            5'd3:  cw = '{ACT_LIT,          CHAR_N,     1'b1, STEP_FETCH};
            5'd4:  cw = '{ACT_LOAD_LINE,    8'h00,      1'b0, STEP_FETCH};
            5'd5:  cw = '{ACT_DABBLE,       8'h00,      1'b0, STEP_FETCH};
            5'd6:  cw = '{ACT_SKIP,         8'h00,      1'b0, STEP_FETCH};
            5'd7:  cw = '{ACT_DIGIT,        8'h00,      1'b1, STEP_FETCH};
            5'd8:  cw = '{ACT_LIT,          CHAR_SPACE, 1'b1, STEP_FETCH};
            5'd9:  cw = '{ACT_DATA,         8'h00,      1'b1, STEP_FETCH};
            5'd10: cw = '{ACT_JMP_NOT_LAST, 8'h00,      1'b0, STEP_FETCH};
            5'd11: cw = '{ACT_JMP_PLAIN,    8'h00,      1'b0, STEP_CR};
            5'd12: cw = '{ACT_LIT,          CHAR_SPACE, 1'b0, STEP_FETCH};
            5'd13: cw = '{ACT_LIT,          CHAR_STAR,  1'b0, STEP_FETCH};
            5'd14: cw = '{ACT_LOAD_SUM,     8'h00,      1'b0, STEP_FETCH};
            5'd15: cw = '{ACT_DABBLE,       8'h00,      1'b0, STEP_FETCH};
            5'd16: cw = '{ACT_SKIP,         8'h00,      1'b0, STEP_FETCH};
            5'd17: cw = '{ACT_DIGIT,        8'h00,      1'b0, STEP_FETCH};
            5'd18: cw = '{ACT_LIT,          CHAR_CR,    1'b0, STEP_FETCH};
            5'd19: cw = '{ACT_LF,           CHAR_LF,    1'b0, STEP_FETCH};
            default: cw = '{ACT_FETCH,      8'h00,      1'b0, STEP_FETCH};
        endcase
        return cw;
    endfunction

endpackage

/* src/gcf_in_if.sv */
interface gcf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        end_of_block;
    logic [31:0] line_number;

    modport source (output valid, data_byte, byte_present, end_of_block, line_number,
                    input ready);
    modport sink (input valid, data_byte, byte_present, end_of_block, line_number,
                  output ready);
endinterface

/* src/gcf_out_if.sv */
interface gcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       frame_error;

    modport source (output valid, out_byte, frame_end, frame_error, input ready);
    modport sink (input valid, out_byte, frame_end, frame_error, output ready);
endinterface

/* src/gcode_line_framer.sv */
// A data byte inside a block passes the open and data steps into the output register, and the
// input takes the next item only after the end-of-block test. Opening a block adds a mode jump
// in plain mode; numbered mode adds a 32-step shift-and-add-3 conversion of the line number,
// leading-zero skip and one digit per cycle. Closing adds a CR jump in plain mode and an
// 8-step checksum conversion in numbered mode. Each byte waits for a free output register.
// Reset (rst_n low, asynchronous) clears the sequencer, the frame state and the mode to 0.
module gcode_line_framer (
    input  logic         clk,
    input  logic         rst_n,
    gcf_in_if.sink       cmd,
    gcf_out_if.source    frame,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data
);

    gcf_pkg::ctrl_t cw;

    // Control and frame state.
    gcf_pkg::step_t step_reg, step_next;
    logic           mode_reg;
    logic           inside_reg, inside_next;
    logic [7:0]     xor_reg, xor_next;
    logic [8:0]     len_reg, len_next;
    logic           ovf_reg, ovf_next;
    logic           out_valid_reg, out_valid_next;

    // Latched input item.
    logic [7:0]     data_reg, data_next;
    logic           present_reg, present_next;
    logic           last_reg, last_next;
    logic [31:0]    line_reg, line_next;

    // Binary-to-decimal converter.
    logic [31:0]    bin_reg, bin_next;
    logic [39:0]    bcd_reg, bcd_next;
    logic [39:0]    bcd_adj;
    logic [4:0]     iter_reg, iter_next;
    logic [3:0]     rem_reg, rem_next;

    // Output register payload.
    logic [7:0]     obyte_reg, obyte_next;
    logic           oend_reg, oend_next;
    logic           oerr_reg, oerr_next;

    // Emit request from the current step.
    logic           can_emit;
    logic           emit_en;
    logic           emit_summed;
    logic [7:0]     emit_byte;

    assign cw = gcf_pkg::ucode(step_reg);
    assign can_emit = !out_valid_reg || frame.ready;

    assign cmd.ready         = (cw.act == gcf_pkg::ACT_FETCH);
    assign frame.valid       = out_valid_reg;
    assign frame.out_byte    = obyte_reg;
    assign frame.frame_end   = oend_reg;
    assign frame.frame_error = oerr_reg;

    // Add 3 to every BCD digit of 5 or more before the next shift.
    always_comb
    begin
        for (int i = 0; i < gcf_pkg::DEC_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        step_next      = step_reg;
        inside_next    = inside_reg;
        xor_next       = xor_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        data_next      = data_reg;
        present_next   = present_reg;
        last_next      = last_reg;
        line_next      = line_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        iter_next      = iter_reg;
        rem_next       = rem_reg;
        emit_en        = 1'b0;
        emit_summed    = cw.summed;
        emit_byte      = cw.lit;
        out_valid_next = out_valid_reg && !frame.ready;
        obyte_next     = obyte_reg;
        oend_next      = oend_reg;
        oerr_next      = oerr_reg;

        unique case (cw.act)
            gcf_pkg::ACT_FETCH:
            begin
                if (cmd.valid)
                begin
                    data_next    = cmd.data_byte;
                    present_next = cmd.byte_present;
                    last_next    = cmd.end_of_block;
                    line_next    = cmd.line_number;
                    step_next    = step_reg + 5'd1;
                end
            end
            gcf_pkg::ACT_OPEN:
            begin
                if (inside_reg)
                begin
                    step_next = cw.target;
                end
                else
                begin
                    inside_next = 1'b1;
                    xor_next    = 8'h00;
                    len_next    = 9'd0;
                    ovf_next    = 1'b0;
                    step_next   = step_reg + 5'd1;
                end
            end
            gcf_pkg::ACT_JMP_PLAIN:
            begin
                step_next = mode_reg ? step_reg + 5'd1 : cw.target;
            end
            gcf_pkg::ACT_JMP_NOT_LAST:
            begin
                step_next = last_reg ? step_reg + 5'd1 : cw.target;
            end
            gcf_pkg::ACT_LIT:
            begin
                if (can_emit)
                begin
                    emit_en   = 1'b1;
                    step_next = step_reg + 5'd1;
                end
            end
            gcf_pkg::ACT_DATA:
            begin
                emit_byte = data_reg;
                if (!present_reg)
                begin
                    step_next = step_reg + 5'd1;
                end
                else if (can_emit)
                begin
                    emit_en   = 1'b1;
                    step_next = step_reg + 5'd1;
                end
            end
            gcf_pkg::ACT_LOAD_LINE:
            begin
                bin_next  = line_reg;
                bcd_next  = '0;
                iter_next = 5'd0;
                rem_next  = gcf_pkg::DEC_DIGITS_CODE;
                step_next = step_reg + 5'd1;
            end
            gcf_pkg::ACT_LOAD_SUM:
            begin
                // The checksum sits in the top byte so only eight shifts remain.
                bin_next  = {xor_reg, 24'h000000};
                bcd_next  = '0;
                iter_next = gcf_pkg::DABBLE_FROM_SUM;
                rem_next  = gcf_pkg::DEC_DIGITS_CODE;
                step_next = step_reg + 5'd1;
            end
            gcf_pkg::ACT_DABBLE:
            begin
                bcd_next  = {bcd_adj[38:0], bin_reg[31]};
                bin_next  = {bin_reg[30:0], 1'b0};
                iter_next = iter_reg + 5'd1;
                if (iter_reg == gcf_pkg::DABBLE_LAST)
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            gcf_pkg::ACT_SKIP:
            begin
                // Drop leading zeros but keep at least one digit.
                if (bcd_reg[39:36] == 4'd0 && rem_reg > 4'd1)
                begin
                    bcd_next = {bcd_reg[35:0], 4'h0};
                    rem_next = rem_reg - 4'd1;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            gcf_pkg::ACT_DIGIT:
            begin
                emit_byte = {gcf_pkg::ASCII_DIGIT_HI, bcd_reg[39:36]};
                if (can_emit)
                begin
                    emit_en  = 1'b1;
                    bcd_next = {bcd_reg[35:0], 4'h0};
                    rem_next = rem_reg - 4'd1;
                    if (rem_reg == 4'd1)
                    begin
                        step_next = step_reg + 5'd1;
                    end
                end
            end
            gcf_pkg::ACT_LF:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    obyte_next     = cw.lit;
                    oend_next      = 1'b1;
                    oerr_next      = ovf_reg || (len_reg >= gcf_pkg::FRAME_MAX);
                    inside_next    = 1'b0;
                    xor_next       = 8'h00;
                    len_next       = 9'd0;
                    ovf_next       = 1'b0;
                    step_next      = cw.target;
                end
            end
            default:
            begin
                step_next = gcf_pkg::STEP_FETCH;
            end
        endcase

        // A byte other than the closing LF goes out and is counted.
        if (emit_en)
        begin
            out_valid_next = 1'b1;
            obyte_next     = emit_byte;
            oend_next      = 1'b0;
            oerr_next      = 1'b0;
            if (emit_summed)
            begin
                xor_next = xor_reg ^ emit_byte;
            end
            if (len_reg >= gcf_pkg::FRAME_MAX)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + 9'd1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= gcf_pkg::STEP_FETCH;
            mode_reg      <= 1'b0;
            inside_reg    <= 1'b0;
            xor_reg       <= 8'h00;
            len_reg       <= 9'd0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            inside_reg    <= inside_next;
            xor_reg       <= xor_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        data_reg    <= data_next;
        present_reg <= present_next;
        last_reg    <= last_next;
        line_reg    <= line_next;
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        iter_reg    <= iter_next;
        rem_reg     <= rem_next;
        obyte_reg   <= obyte_next;
        oend_reg    <= oend_next;
        oerr_reg    <= oerr_next;
    end

endmodule
